>>> hdl/sird_pkg.sv
// shared constants, types and the symbol lookup for the signed radix text block
// no dependencies; every other file uses it by scoped names
`timescale 1ns / 1ps
package sird_pkg;

   // widths and limits
   localparam int NUMBER_BITS  = 32;
   localparam int MAX_SYMBOLS  = 16;
   localparam int SYM_IDX_W    = 4;
   localparam int COUNT_W      = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int STACK_DEPTH  = 32;
   localparam int STACK_ADDR_W = 5;
   localparam int DIGIT_CNT_W  = 6;

   // divider: bits retired per cycle and steps per digit
   localparam int DIV_CHUNK    = 8;
   localparam int DIV_STEPS    = NUMBER_BITS / DIV_CHUNK;
   localparam int DIV_STEP_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // characters
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // reset values: "0123456789abcdef", radix 16
   localparam logic [COUNT_W-1:0]    RST_SYMBOL_COUNT = 5'd16;
   localparam logic [CSR_DATA_W-1:0] RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] RST_SYMBOLS_HIGH = 64'h6665_6463_6261_3938;

   typedef logic [7:0] char_type;

   // byte idx of the alphabet, low word holds symbols 0 to 7
   function automatic char_type symbol_at(input logic [CSR_DATA_W-1:0] lo,
                                          input logic [CSR_DATA_W-1:0] hi,
                                          input logic [SYM_IDX_W-1:0]  idx);
      logic [CSR_DATA_W-1:0] word;
      word = idx[SYM_IDX_W-1] ? hi : lo;
      return word[idx[SYM_IDX_W-2:0]*8 +: 8];
   endfunction

endpackage

>>> hdl/sird_req_if.sv
// input channel: one signed number per beat
// depends on sird_pkg
`timescale 1ns / 1ps
interface sird_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sird_pkg::NUMBER_BITS-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

>>> hdl/sird_rsp_if.sv
// result channel: one text character per beat, last marks the end of a number
// depends on sird_pkg
`timescale 1ns / 1ps
interface sird_rsp_if;
   logic                valid;
   logic                ready;
   sird_pkg::char_type  character;
   logic                last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hdl/sird_alpha_chk.sv
// alphabet check: radix in range, no nul, plus or minus, no repeated symbol
// depends on sird_pkg
`timescale 1ns / 1ps
module sird_alpha_chk (
   input  logic [sird_pkg::COUNT_W-1:0]    symbol_count,
   input  logic [sird_pkg::CSR_DATA_W-1:0] symbols_low,
   input  logic [sird_pkg::CSR_DATA_W-1:0] symbols_high,
   output logic                            alpha_ok
);

   sird_pkg::char_type sym [sird_pkg::MAX_SYMBOLS];

   // unpack the symbol bytes
   always_comb begin
      for (int i = 0; i < sird_pkg::MAX_SYMBOLS; i++) begin
         sym[i] = sird_pkg::symbol_at(symbols_low, symbols_high,
                                      sird_pkg::SYM_IDX_W'(i));
      end
   end

   // all compares in parallel, only positions below the count take part
   always_comb begin
      logic bad;
      bad = (symbol_count < sird_pkg::COUNT_W'(2)) ||
            (symbol_count > sird_pkg::COUNT_W'(sird_pkg::MAX_SYMBOLS));
      for (int i = 0; i < sird_pkg::MAX_SYMBOLS; i++) begin
         if (sird_pkg::COUNT_W'(i) < symbol_count) begin
            if (sym[i] == sird_pkg::CHAR_NUL || sym[i] == sird_pkg::CHAR_PLUS ||
                sym[i] == sird_pkg::CHAR_MINUS) begin
               bad = 1'b1;
            end
            for (int j = i + 1; j < sird_pkg::MAX_SYMBOLS; j++) begin
               if (sird_pkg::COUNT_W'(j) < symbol_count && sym[j] == sym[i]) begin
                  bad = 1'b1;
               end
            end
         end
      end
      alpha_ok = !bad;
   end

endmodule

>>> hdl/sird_div.sv
// iterative divider by the radix: DIV_CHUNK quotient bits per cycle
// depends on sird_pkg; the start cycle loads the dividend, done flags the last chunk
`timescale 1ns / 1ps
module sird_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sird_pkg::NUMBER_BITS-1:0] dividend,
   input  logic [sird_pkg::COUNT_W-1:0]     radix,
   output logic                             done,
   output logic [sird_pkg::NUMBER_BITS-1:0] quotient,
   output logic [sird_pkg::SYM_IDX_W-1:0]   remainder
);

   logic                               running_ff, running_in;
   logic [sird_pkg::DIV_STEP_W-1:0]    step_ff, step_in;
   logic [sird_pkg::NUMBER_BITS-1:0]   acc_ff, acc_in;
   logic [sird_pkg::SYM_IDX_W-1:0]     rem_ff, rem_in;
   logic [sird_pkg::NUMBER_BITS-1:0]   chunk_quot;
   logic [sird_pkg::SYM_IDX_W-1:0]     chunk_rem;

   // one chunk of restoring division on the held partial result
   always_comb begin
      logic [sird_pkg::NUMBER_BITS-1:0] a;
      logic [sird_pkg::SYM_IDX_W-1:0]   r;
      logic [sird_pkg::COUNT_W-1:0]     t;
      logic                             ge;
      a = acc_ff;
      r = rem_ff;
      for (int k = 0; k < sird_pkg::DIV_CHUNK; k++) begin
         t  = {r, a[sird_pkg::NUMBER_BITS-1]};
         ge = (t >= radix);
         a  = {a[sird_pkg::NUMBER_BITS-2:0], ge};
         r  = ge ? sird_pkg::SYM_IDX_W'(t - radix) : t[sird_pkg::SYM_IDX_W-1:0];
      end
      chunk_quot = a;
      chunk_rem  = r;
   end

   // start loads a fresh dividend, otherwise the chunk result is kept
   assign acc_in = start ? dividend : chunk_quot;
   assign rem_in = start ? '0 : chunk_rem;

   // step count
   assign done = running_ff && (step_ff == sird_pkg::DIV_STEP_W'(sird_pkg::DIV_STEPS - 1));

   always_comb begin
      if (start) begin
         running_in = 1'b1;
         step_in    = '0;
      end else if (done) begin
         running_in = 1'b0;
         step_in    = '0;
      end else begin
         running_in = running_ff;
         step_in    = running_ff ? step_ff + 1'b1 : step_ff;
      end
   end

   assign quotient  = chunk_quot;
   assign remainder = chunk_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= '0;
         acc_ff     <= '0;
      end else begin
         running_ff <= running_in;
         step_ff    <= step_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

endmodule

>>> hdl/signed_integer_to_radix_digits.sv
// top level: signed number to text in a configurable radix
// depends on sird_pkg, sird_req_if, sird_rsp_if, sird_alpha_chk, sird_div
//
// Takes one signed 32-bit number per beat and returns its text, one character
// per beat: a '-' for negative numbers, then the magnitude digits most
// significant first, with last set on the final character. The radix is the
// configured symbol count and the digits are shown with the configured symbols;
// an invalid alphabet (count below 2 or above 16, a nul, '+' or '-' symbol, or a
// repeated symbol) swallows the number with no output. The digits are produced
// least significant first by a divider that retires 8 quotient bits per cycle
// and pushed into a 32 x 4 digit stack memory; they are then read back out,
// one character per cycle while the output is taken. The next number is
// accepted once the last character has moved to the output register.
`timescale 1ns / 1ps
module signed_integer_to_radix_digits (
   input  logic                                clock,
   input  logic                                reset,
   sird_req_if.sink                            req_chan,
   sird_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [sird_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sird_pkg::CSR_DATA_W-1:0]     csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SIGN = 4'b0100,
      ST_SHOW = 4'b1000
   } state_type;

   state_type                                state_ff, state_in;
   logic [sird_pkg::COUNT_W-1:0]             symbol_count_ff;
   logic [sird_pkg::CSR_DATA_W-1:0]          symbols_low_ff;
   logic [sird_pkg::CSR_DATA_W-1:0]          symbols_high_ff;
   logic                                     neg_ff, neg_in;
   logic [sird_pkg::DIGIT_CNT_W-1:0]         count_ff, count_in;
   logic                                     rd_pend_ff, rd_pend_in;
   logic                                     rd_last_ff, rd_last_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   sird_pkg::char_type                       char_ff, char_in;
   logic                                     last_ff, last_in;

   logic [sird_pkg::SYM_IDX_W-1:0]           stack_mem [sird_pkg::STACK_DEPTH];
   logic [sird_pkg::SYM_IDX_W-1:0]           rd_data_ff;
   logic                                     mem_we, mem_re;
   logic [sird_pkg::STACK_ADDR_W-1:0]        wr_addr, rd_addr;

   logic                                     accept, alpha_ok, out_free, more;
   logic                                     neg_req;
   logic [sird_pkg::NUMBER_BITS-1:0]         mag;
   logic                                     div_start, div_done;
   logic [sird_pkg::NUMBER_BITS-1:0]         div_dividend, div_quot;
   logic [sird_pkg::SYM_IDX_W-1:0]           div_rem;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= sird_pkg::RST_SYMBOL_COUNT;
         symbols_low_ff  <= sird_pkg::RST_SYMBOLS_LOW;
         symbols_high_ff <= sird_pkg::RST_SYMBOLS_HIGH;
      end else if (csr_write_en) begin
         case (csr_index)
            sird_pkg::CSR_SYMBOL_COUNT: begin
               symbol_count_ff <= csr_data[sird_pkg::COUNT_W-1:0];
            end
            sird_pkg::CSR_SYMBOLS_LOW: begin
               symbols_low_ff <= csr_data;
            end
            sird_pkg::CSR_SYMBOLS_HIGH: begin
               symbols_high_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   sird_alpha_chk u_alpha (
      .symbol_count (symbol_count_ff),
      .symbols_low  (symbols_low_ff),
      .symbols_high (symbols_high_ff),
      .alpha_ok     (alpha_ok)
   );

   // input beat and magnitude, the most negative value maps to 2^(n-1) unsigned
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign neg_req = req_chan.number[sird_pkg::NUMBER_BITS-1];
   assign mag     = neg_req ? (~req_chan.number + 1'b1) : req_chan.number;

   // divider is restarted straight from its own quotient while digits remain
   assign more         = (div_quot != '0) &&
                         (count_ff != sird_pkg::DIGIT_CNT_W'(sird_pkg::STACK_DEPTH - 1));
   assign div_start    = (accept && alpha_ok) || ((state_ff == ST_DIV) && div_done && more);
   assign div_dividend = (state_ff == ST_IDLE) ? mag : div_quot;

   sird_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (symbol_count_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign wr_addr  = count_ff[sird_pkg::STACK_ADDR_W-1:0];
   assign rd_addr  = sird_pkg::STACK_ADDR_W'(count_ff - 1'b1);

   // sequencer: push digits, then the minus sign if any, then pop the digits into the output register
   always_comb begin
      logic load;
      state_in     = state_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      load         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && alpha_ok) begin
               neg_in   = neg_req;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mem_we     = 1'b1;
               count_in   = count_ff + 1'b1;
               rd_pend_in = 1'b0;
               if (!more) begin
                  state_in = neg_ff ? ST_SIGN : ST_SHOW;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = sird_pkg::CHAR_MINUS;
               last_in      = 1'b0;
               state_in     = ST_SHOW;
            end
         end
         ST_SHOW: begin
            load = rd_pend_ff && out_free;
            if (load) begin
               rsp_valid_in = 1'b1;
               char_in      = sird_pkg::symbol_at(symbols_low_ff, symbols_high_ff,
                                                  rd_data_ff);
               last_in      = rd_last_ff;
               rd_pend_in   = 1'b0;
               if (rd_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
            // keep one stack read in flight ahead of the output register
            if ((!rd_pend_ff || load) && count_ff != '0) begin
               mem_re     = 1'b1;
               count_in   = count_ff - 1'b1;
               rd_pend_in = 1'b1;
               rd_last_in = (count_ff == sird_pkg::DIGIT_CNT_W'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // digit stack, writes and reads fall in different states so never collide
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= div_rem;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule

>>> bench/tb_top.sv
// testbench for signed_integer_to_radix_digits: numbers in, text beats out, checked
// depends on sird_pkg, sird_req_if, sird_rsp_if and the block itself
`timescale 1ns / 1ps
module tb_top;

   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD     = 400;

   // default alphabet after reset, "0123456789abcdef"
   localparam logic [63:0] HEX_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] HEX_HIGH = 64'h6665_6463_6261_3938;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   sird_req_if req_bus ();
   sird_rsp_if rsp_bus ();

   signed_integer_to_radix_digits dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // local copy of the alphabet registers
   logic [4:0]  radix_reg    = 5'd16;
   logic [63:0] sym_low_reg  = HEX_LOW;
   logic [63:0] sym_high_reg = HEX_HIGH;

   text_beat_type expected_text[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int fail_count    = 0;
   int numbers_sent  = 0;
   int rejected_numbers = 0;
   int chars_checked = 0;
   int alphabets_applied = 0;

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // symbol lookup in the local alphabet copy
   function automatic logic [7:0] glyph(input int idx);
      if (idx < 8)
         return sym_low_reg[idx*8 +: 8];
      return sym_high_reg[(idx-8)*8 +: 8];
   endfunction

   // alphabet must have 2..16 symbols, none nul, '+' or '-', all distinct
   function automatic logic alphabet_valid();
      logic [7:0] s;
      if (radix_reg < 5'd2 || radix_reg > 5'd16)
         return 1'b0;
      for (int i = 0; i < radix_reg; i++) begin
         s = glyph(i);
         if (s == sird_pkg::CHAR_NUL || s == sird_pkg::CHAR_PLUS ||
             s == sird_pkg::CHAR_MINUS)
            return 1'b0;
         for (int j = i + 1; j < radix_reg; j++)
            if (glyph(j) == s)
               return 1'b0;
      end
      return 1'b1;
   endfunction

   // expected text of one number: optional minus, then digits msd first; none for an invalid alphabet
   function automatic void predict_text(input logic signed [31:0] value);
      logic [31:0] magnitude;
      logic [31:0] radix;
      logic [3:0]  digits [32];
      int          ndig;
      if (!alphabet_valid()) begin
         rejected_numbers++;
         return;
      end
      radix = {27'd0, radix_reg};
      magnitude = value;
      if (value[31])
         magnitude = ~magnitude + 32'd1;
      ndig = 0;
      do begin
         digits[ndig] = 4'(magnitude % radix);
         magnitude = magnitude / radix;
         ndig++;
      end while (magnitude != 0);
      if (value[31])
         expected_text.push_back('{character: sird_pkg::CHAR_MINUS, last: 1'b0});
      for (int i = ndig - 1; i >= 0; i--)
         expected_text.push_back('{character: glyph(digits[i]), last: (i == 0)});
   endfunction

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare every result beat with the oldest expected character
   always @(posedge clock) begin
      text_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_text.size() == 0) begin
            $error("unexpected beat: character %h last %b", rsp_bus.character, rsp_bus.last);
            fail_count++;
         end else begin
            want = expected_text.pop_front();
            chars_checked++;
            if (rsp_bus.character !== want.character) begin
               $error("character: expected %h, actual %h", want.character, rsp_bus.character);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // one number beat, with random idle cycles in front
   task automatic send_number(input logic signed [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.number <= value;
      do @(posedge clock); while (!req_bus.ready);
      numbers_sent++;
      predict_text(value);
   endtask

   // stop sending, wait for all text, then let the block settle
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [63:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         sird_pkg::CSR_SYMBOL_COUNT: radix_reg    = data[4:0];
         sird_pkg::CSR_SYMBOLS_LOW:  sym_low_reg  = data;
         sird_pkg::CSR_SYMBOLS_HIGH: sym_high_reg = data;
         default: ;
      endcase
   endtask

   task automatic apply_alphabet(input logic [4:0] count, input logic [63:0] lo,
                                 input logic [63:0] hi);
      wait_drained();
      write_csr(sird_pkg::CSR_SYMBOL_COUNT, {59'd0, count});
      write_csr(sird_pkg::CSR_SYMBOLS_LOW, lo);
      write_csr(sird_pkg::CSR_SYMBOLS_HIGH, hi);
      alphabets_applied++;
   endtask

   // mostly valid alphabets with random symbols, now and then a broken one
   task automatic random_alphabet(output logic [4:0] count, output logic [63:0] lo,
                                  output logic [63:0] hi);
      logic [7:0] glyphs [16];
      logic [7:0] pick;
      logic       clash;
      case ($urandom_range(9))
         0:       count = 5'd2;
         1:       count = 5'd16;
         default: count = 5'($urandom_range(2, 16));
      endcase
      for (int i = 0; i < 16; i++) begin
         if (i >= count) begin
            glyphs[i] = 8'($urandom_range(255));
         end else begin
            do begin
               pick  = 8'($urandom_range(255));
               clash = (pick == sird_pkg::CHAR_NUL || pick == sird_pkg::CHAR_PLUS ||
                        pick == sird_pkg::CHAR_MINUS);
               for (int j = 0; j < i; j++)
                  clash |= (glyphs[j] == pick);
            end while (clash);
            glyphs[i] = pick;
         end
      end
      case ($urandom_range(24))
         0: glyphs[$urandom_range(count - 1)] = sird_pkg::CHAR_MINUS;
         1: glyphs[$urandom_range(count - 1)] = sird_pkg::CHAR_PLUS;
         2: glyphs[$urandom_range(count - 1)] = sird_pkg::CHAR_NUL;
         3: glyphs[count - 1] = glyphs[$urandom_range(count - 2)];
         4: count = $urandom_range(1) ? 5'($urandom_range(1)) : 5'($urandom_range(17, 31));
         default: ;
      endcase
      for (int i = 0; i < 8; i++) begin
         lo[i*8 +: 8] = glyphs[i];
         hi[i*8 +: 8] = glyphs[i+8];
      end
   endtask

   function automatic logic signed [31:0] random_number();
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = 32'($urandom_range(40)) - 32'd20;
         1: begin
            case ($urandom_range(4))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0;
               3: v = 32'hffff_ffff;
               default: v = 32'h1;
            endcase
         end
         2: v = $urandom >> $urandom_range(31);
         3: v = -($urandom >> $urandom_range(31));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // reset alphabet: hex digits, extremes and sign handling
   task automatic test_reset_alphabet();
      send_idle_pct = 20;
      recv_idle_pct = 30;
      send_number(32'sd0);
      send_number(32'sd1);
      send_number(-32'sd1);
      send_number(32'sh7fff_ffff);
      send_number(32'sh8000_0000);
      send_number(32'sd15);
      send_number(-32'sd16);
   endtask

   // smallest and largest radix plus a few in between
   task automatic test_radix_extremes();
      apply_alphabet(5'd2, 64'h2d2b_0000_ffff_3130, 64'h0);
      send_number(32'sh8000_0000);
      send_number(32'sh7fff_ffff);
      apply_alphabet(5'd10, HEX_LOW, 64'h0000_0000_0000_3938);
      send_number(-32'sd1234567890);
      send_number(32'sd0);
      apply_alphabet(5'd3, 64'h0000_0000_007a_7978, 64'h0);
      send_number(32'sd7);
      send_number(-32'sd8);
      apply_alphabet(5'd16, HEX_LOW, 64'h4645_4443_4241_3938);
      send_number(-32'sd1);
      send_number(32'sh7fff_ffff);
   endtask

   // every way the alphabet can be rejected, whose numbers give no text, and one valid case
   task automatic test_bad_alphabets();
      logic [63:0] lo;
      logic [63:0] hi;
      apply_alphabet(5'd0, HEX_LOW, HEX_HIGH);
      send_number(-32'sd123);
      apply_alphabet(5'd1, HEX_LOW, HEX_HIGH);
      send_number(-32'sd123);
      apply_alphabet(5'd17, HEX_LOW, HEX_HIGH);
      send_number(-32'sd123);
      apply_alphabet(5'd31, HEX_LOW, HEX_HIGH);
      send_number(-32'sd123);
      // plus as the very first symbol
      lo = HEX_LOW;
      lo[7:0] = sird_pkg::CHAR_PLUS;
      apply_alphabet(5'd16, lo, HEX_HIGH);
      send_number(32'sd123);
      // minus as the very first symbol
      lo[7:0] = sird_pkg::CHAR_MINUS;
      apply_alphabet(5'd16, lo, HEX_HIGH);
      send_number(32'sd123);
      // minus in the upper word
      hi = HEX_HIGH;
      hi[15:8] = sird_pkg::CHAR_MINUS;
      apply_alphabet(5'd16, HEX_LOW, hi);
      send_number(32'sd123);
      // nul symbol
      lo = HEX_LOW;
      lo[31:24] = sird_pkg::CHAR_NUL;
      apply_alphabet(5'd16, lo, HEX_HIGH);
      send_number(32'sd123);
      // symbol 12 repeats symbol 2
      hi = HEX_HIGH;
      hi[39:32] = 8'h32;
      apply_alphabet(5'd16, HEX_LOW, hi);
      send_number(32'sd123);
      // bad bytes beyond the count do not matter
      lo = HEX_LOW;
      lo[55:48] = sird_pkg::CHAR_MINUS;
      apply_alphabet(5'd5, lo, 64'h0);
      send_number(32'sh8000_0000);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int items);
      logic [4:0]  count;
      logic [63:0] lo;
      logic [63:0] hi;
      for (int sent = 0; sent < items; sent++) begin
         if (sent % 6 == 0) begin
            random_alphabet(count, lo, hi);
            apply_alphabet(count, lo, hi);
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
         end
         send_number(random_number());
      end
   endtask

   // receiver holds off while numbers keep coming, then sender waits for all text and sends three more
   task automatic test_output_stall();
      apply_alphabet(5'd2, 64'h0000_0000_0000_6c6f, 64'h0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = LONG_HOLD;
      for (int i = 0; i < 5; i++)
         send_number(random_number());
      wait_drained();
      for (int i = 0; i < 3; i++)
         send_number(random_number());
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.number = '0;
      rsp_bus.ready  = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = sird_pkg::CSR_SYMBOL_COUNT;
      csr_data       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_alphabet();
      test_radix_extremes();
      test_bad_alphabets();
      test_random_traffic(37, 57, 26);
      test_random_traffic(57, 37, 26);
      test_random_traffic(0, 0, 26);
      test_output_stall();
      wait_drained();

      $display("summary: %0d numbers sent, %0d swallowed by invalid alphabets, %0d chars checked",
               numbers_sent, rejected_numbers, chars_checked);
      $display("summary: %0d alphabets applied, radix 2 to 16, bad settings, long output stall",
               alphabets_applied);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
hdl/sird_pkg.sv
hdl/sird_req_if.sv
hdl/sird_rsp_if.sv
hdl/sird_alpha_chk.sv
hdl/sird_div.sv
hdl/signed_integer_to_radix_digits.sv
bench/tb_top.sv
